// File: hw/rtl/rplt_pkg.sv
// Shared constants, command and status codes, and op/result types for the ranked list table.
package rplt_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int CMD_W   = 3;
    localparam int POS_W   = 8;
    localparam int RANK_W  = 16;
    localparam int PRICE_W = 32;
    localparam int TAG_W   = 16;
    localparam int STAT_W  = 2;
    localparam int KIND_W  = 3;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CHANGE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    localparam logic [KIND_W-1:0] K_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] K_DELETE = 3'd1;
    localparam logic [KIND_W-1:0] K_CHANGE = 3'd2;
    localparam logic [KIND_W-1:0] K_CLEAR  = 3'd3;
    localparam logic [KIND_W-1:0] K_READ   = 3'd4;
    localparam logic [KIND_W-1:0] K_NOP    = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [POS_W-1:0]          pos;
        logic signed [RANK_W-1:0]  rank;
        logic [PRICE_W-1:0]        price;
        logic [TAG_W-1:0]          tag;
    } t_op;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [RANK_W-1:0]  rank;
        logic [PRICE_W-1:0]        price;
        logic [TAG_W-1:0]          tag;
    } t_res;

endpackage

// File: hw/rtl/rplt_front.sv
// Front end: accept commands and classify them into ops for the back end.
module rplt_front import rplt_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [CMD_W-1:0]          i_command,
    input  logic [POS_W-1:0]          i_position,
    input  logic signed [RANK_W-1:0]  i_item_rank,
    input  logic [PRICE_W-1:0]        i_item_price,
    input  logic [TAG_W-1:0]          i_item_tag,
    output logic                      o_op_valid,
    output t_op                       o_op,
    input  logic                      i_op_ready
);

    logic              r_valid;
    logic              n_valid;
    t_op               r_op;
    logic              accept;
    logic [KIND_W-1:0] kind;

    always_comb begin
        unique case (i_command)
            CMD_INSERT: kind = K_INSERT;
            CMD_DELETE: kind = K_DELETE;
            CMD_CHANGE: kind = K_CHANGE;
            CMD_CLEAR:  kind = K_CLEAR;
            CMD_READ:   kind = K_READ;
            default:    kind = K_NOP;
        endcase
    end

    assign full   = r_valid & ~i_op_ready;
    assign accept = push & ~full;

    always_comb begin
        n_valid = accept | (r_valid & ~i_op_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op.kind  <= kind;
            r_op.pos   <= i_position;
            r_op.rank  <= i_item_rank;
            r_op.price <= i_item_price;
            r_op.tag   <= i_item_tag;
        end
    end

    assign o_op_valid = r_valid;
    assign o_op       = r_op;

endmodule

// File: hw/rtl/rplt_queue.sv
// Two-entry op queue between the front end and the back end.
module rplt_queue import rplt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    output logic o_wr_ready,
    input  t_op  i_wr_op,
    output logic o_rd_valid,
    input  logic i_rd_ready,
    output t_op  o_rd_op
);

    t_op        r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       wr;
    logic       rd;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_op    = r_mem[r_rp];
    assign wr         = i_wr_valid & o_wr_ready;
    assign rd         = i_rd_ready & o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_wr_op;
        end
    end

endmodule

// File: hw/rtl/rplt_back.sv
// Back end: table memories, fill count, insert/delete walk sequencer and result register.
module rplt_back import rplt_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_op_valid,
    input  t_op                          i_op,
    output logic                         o_op_ready,
    output logic                         o_res_valid,
    output t_res                         o_res,
    output logic [$clog2(DEPTH+1)-1:0]   o_total,
    input  logic                         i_pop
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_INSZ = 3'd2;
    localparam logic [2:0] S_DEL  = 3'd3;
    localparam logic [2:0] S_RDW  = 3'd4;

    logic signed [RANK_W-1:0] r_mem_rank  [DEPTH];
    logic [PRICE_W-1:0]       r_mem_price [DEPTH];
    logic [TAG_W-1:0]         r_mem_tag   [DEPTH];

    logic signed [RANK_W-1:0] r_rd_rank;
    logic [PRICE_W-1:0]       r_rd_price;
    logic [TAG_W-1:0]         r_rd_tag;

    logic [2:0]    r_state, n_state;
    logic [IW-1:0] r_cursor, n_cursor;
    logic [CW-1:0] r_fill, n_fill;
    t_op           r_op, n_op;
    logic          r_out_valid;
    t_res          r_out;
    logic [CW-1:0] r_out_total;

    logic                     out_free;
    logic                     load;
    t_res                     res;
    logic [IW-1:0]            rd_addr;
    logic                     wr_row_en;
    logic                     wr_price_en;
    logic [IW-1:0]            wr_addr;
    logic signed [RANK_W-1:0] wr_rank;
    logic [PRICE_W-1:0]       wr_price;
    logic [TAG_W-1:0]         wr_tag;
    logic [PW-1:0]            pos_w;
    logic [PW-1:0]            fill_w;
    logic [STAT_W-1:0]        loc_status;
    logic [IW-1:0]            idx;
    logic [IW-1:0]            last;
    logic                     tbl_full;

    assign out_free = ~r_out_valid | i_pop;
    assign pos_w    = PW'(i_op.pos);
    assign fill_w   = PW'(r_fill);
    assign idx      = IW'(pos_w - PW'(1));
    assign last     = IW'(r_fill - 1'b1);
    assign tbl_full = (r_fill == CW'(DEPTH));

    always_comb begin
        if (r_fill == '0) begin
            loc_status = ST_EMPTY;
        end else if (pos_w == '0 || pos_w > fill_w) begin
            loc_status = ST_BADPOS;
        end else begin
            loc_status = ST_OK;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_fill      = r_fill;
        n_op        = r_op;
        o_op_ready  = 1'b0;
        rd_addr     = r_cursor;
        wr_row_en   = 1'b0;
        wr_price_en = 1'b0;
        wr_addr     = r_cursor;
        wr_rank     = r_op.rank;
        wr_price    = r_op.price;
        wr_tag      = r_op.tag;
        load        = 1'b0;
        res         = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_op_valid && out_free) begin
                    o_op_ready = 1'b1;
                    n_op       = i_op;
                    wr_rank    = i_op.rank;
                    wr_price   = i_op.price;
                    wr_tag     = i_op.tag;
                    case (i_op.kind)
                        K_INSERT: begin
                            if (tbl_full) begin
                                load       = 1'b1;
                                res.status = ST_FULL;
                            end else if (r_fill == '0) begin
                                wr_row_en = 1'b1;
                                wr_addr   = '0;
                                n_fill    = r_fill + 1'b1;
                                load      = 1'b1;
                            end else begin
                                n_cursor = last;
                                rd_addr  = last;
                                n_state  = S_INS;
                            end
                        end
                        K_DELETE: begin
                            if (loc_status != ST_OK) begin
                                load       = 1'b1;
                                res.status = loc_status;
                            end else if (idx == last) begin
                                n_fill = r_fill - 1'b1;
                                load   = 1'b1;
                            end else begin
                                n_cursor = idx + 1'b1;
                                rd_addr  = idx + 1'b1;
                                n_state  = S_DEL;
                            end
                        end
                        K_CHANGE: begin
                            wr_price_en = (loc_status == ST_OK);
                            wr_addr     = idx;
                            load        = 1'b1;
                            res.status  = loc_status;
                        end
                        K_CLEAR: begin
                            n_fill = '0;
                            load   = 1'b1;
                        end
                        K_READ: begin
                            if (loc_status == ST_OK) begin
                                rd_addr = idx;
                                n_state = S_RDW;
                            end else begin
                                load       = 1'b1;
                                res.status = loc_status;
                            end
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_INS: begin
                wr_row_en = 1'b1;
                wr_addr   = r_cursor + 1'b1;
                if ($signed(r_op.rank) > $signed(r_rd_rank)) begin
                    wr_rank  = r_rd_rank;
                    wr_price = r_rd_price;
                    wr_tag   = r_rd_tag;
                    if (r_cursor == '0) begin
                        n_state = S_INSZ;
                    end else begin
                        n_cursor = r_cursor - 1'b1;
                        rd_addr  = r_cursor - 1'b1;
                    end
                end else begin
                    n_fill  = r_fill + 1'b1;
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_INSZ: begin
                wr_row_en = 1'b1;
                wr_addr   = '0;
                n_fill    = r_fill + 1'b1;
                load      = 1'b1;
                n_state   = S_IDLE;
            end
            S_DEL: begin
                wr_row_en = 1'b1;
                wr_addr   = r_cursor - 1'b1;
                wr_rank   = r_rd_rank;
                wr_price  = r_rd_price;
                wr_tag    = r_rd_tag;
                if (r_cursor == last) begin
                    n_fill  = r_fill - 1'b1;
                    load    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cursor = r_cursor + 1'b1;
                    rd_addr  = r_cursor + 1'b1;
                end
            end
            S_RDW: begin
                res.rank  = r_rd_rank;
                res.price = r_rd_price;
                res.tag   = r_rd_tag;
                load      = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_row_en) begin
            r_mem_rank[wr_addr] <= wr_rank;
            r_mem_tag[wr_addr]  <= wr_tag;
        end
        if (wr_row_en || wr_price_en) begin
            r_mem_price[wr_addr] <= wr_price;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_rank  <= r_mem_rank[rd_addr];
        r_rd_price <= r_mem_price[rd_addr];
        r_rd_tag   <= r_mem_tag[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cursor <= n_cursor;
        r_op     <= n_op;
        if (load) begin
            r_out       <= res;
            r_out_total <= n_fill;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
    assign o_total     = r_out_total;

`ifndef SYNTHESIS
    a_walk_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("result register busy during a table walk");

    a_fill_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != $past(r_fill)) |-> $past(load))
        else $error("fill count changed without a result");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_FULL) |-> (r_fill == CW'(DEPTH)))
        else $error("full status reported on a table with room");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_out_total == r_fill))
        else $error("reported entry total differs from fill count");
`endif

endmodule

// File: hw/rtl/ranked_priority_list_table.sv
// Ranked priority list table top level: front end, op queue and back end.
// A command passes through the front register and the op queue, then the back end: clear,
//   change, unused and rejected commands load a result directly; read waits on a registered row
//   read; delete shifts the rows after position p down; insert shifts rows ranked below it up.
// Throughput: one command in the back end at a time; the next starts as its result is popped.
// Reset (synchronous, active low) empties the table and queues; entry memories keep data.
module ranked_priority_list_table import rplt_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [CMD_W-1:0]            i_command,
    input  logic [POS_W-1:0]            i_position,
    input  logic signed [RANK_W-1:0]    i_item_rank,
    input  logic [PRICE_W-1:0]          i_item_price,
    input  logic [TAG_W-1:0]            i_item_tag,
    output logic                        empty,
    input  logic                        pop,
    output logic [STAT_W-1:0]           o_status,
    output logic signed [RANK_W-1:0]    o_out_rank,
    output logic [PRICE_W-1:0]          o_out_price,
    output logic [TAG_W-1:0]            o_out_tag,
    output logic [$clog2(DEPTH+1)-1:0]  o_entry_total
);

    logic f_valid;
    logic f_ready;
    t_op  f_op;
    logic q_valid;
    logic q_ready;
    t_op  q_op;
    logic res_valid;
    t_res res;

    rplt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_command    (i_command),
        .i_position   (i_position),
        .i_item_rank  (i_item_rank),
        .i_item_price (i_item_price),
        .i_item_tag   (i_item_tag),
        .o_op_valid   (f_valid),
        .o_op         (f_op),
        .i_op_ready   (f_ready)
    );

    rplt_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .i_wr_op    (f_op),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_op    (q_op)
    );

    rplt_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (q_valid),
        .i_op        (q_op),
        .o_op_ready  (q_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_total     (o_entry_total),
        .i_pop       (pop)
    );

    assign empty       = ~res_valid;
    assign o_status    = res.status;
    assign o_out_rank  = res.rank;
    assign o_out_price = res.price;
    assign o_out_tag   = res.tag;

endmodule
